### rtl/lsia_pkg.sv
`default_nettype none
package lsia_pkg;

	localparam int MAX_INTERVALS_DEF = 64;
	localparam int NUM_PHYS_DEF = 16;
	localparam int SLOT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_DATA_W-1:0] FIRST_GENERAL_RST = 4'd1;
	localparam logic [CFG_DATA_W-1:0] SCRATCH_RST = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_GENERAL = 1'b0,
		CFG_SCRATCH       = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0]  virtual_reg;
		logic [15:0] range_start;
		logic [15:0] range_end;
		logic        final_item;
	} item_t;

	typedef struct packed {
		logic [9:0]        out_virtual_reg;
		logic [3:0]        phys_reg;
		logic              spilled;
		logic [SLOT_W-1:0] spill_slot;
		logic              last_result;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_SCAN_INIT, S_SC_RD, S_SC_LD,
		S_EX_RD, S_EX_CHK, S_FIND, S_AI_RD, S_AI_CMP, S_AI_PUT, S_VS_RD, S_VS_CHK,
		S_VS_DEC, S_VS_EVICT, S_NEXT, S_OUT_RD, S_OUT_RD2, S_OUT_EMIT
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_INS_RD, OP_INS_CMP, OP_INS_PUT, OP_SCAN_INIT, OP_SC_RD,
		OP_SC_LD, OP_EX_RD, OP_EX_CHK, OP_ALLOC, OP_SPILL_CUR, OP_VS_INIT, OP_VS_RD,
		OP_VS_CHK, OP_AI_RD, OP_AI_CMP, OP_AI_PUT, OP_VS_DEC, OP_VS_EVICT, OP_NEXT,
		OP_OUT_RD, OP_OUT_RD2, OP_OUT_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic count_full;
		logic count_zero;
		logic ins_shift;
		logic pos_one;
		logic final_q;
		logic acnt_zero;
		logic j_last;
		logic found;
		logic room;
		logic ai_shift;
		logic apos_one;
		logic vic_wins;
		logic k_last;
	} dp_status_t;

endpackage
`default_nettype wire

### rtl/lsia_ctrl.sv
`default_nettype none
module lsia_ctrl import lsia_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       final_item,
	input  wire dp_status_t status,
	output logic            busy,
	output dp_cmd_t         cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
					if (status.count_full) begin
						state_d = final_item ? S_SCAN_INIT : S_IDLE;
					end else if (status.count_zero) begin
						state_d = S_INS_PUT;
					end else begin
						state_d = S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				cmd.op = OP_INS_RD;
				state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				cmd.op = OP_INS_CMP;
				if (status.ins_shift && !status.pos_one) begin
					state_d = S_INS_RD;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				cmd.op = OP_INS_PUT;
				state_d = status.final_q ? S_SCAN_INIT : S_IDLE;
			end
			S_SCAN_INIT: begin
				cmd.op = OP_SCAN_INIT;
				state_d = S_SC_RD;
			end
			S_SC_RD: begin
				cmd.op = OP_SC_RD;
				state_d = S_SC_LD;
			end
			S_SC_LD: begin
				cmd.op = OP_SC_LD;
				state_d = status.acnt_zero ? S_FIND : S_EX_RD;
			end
			S_EX_RD: begin
				cmd.op = OP_EX_RD;
				state_d = S_EX_CHK;
			end
			S_EX_CHK: begin
				cmd.op = OP_EX_CHK;
				state_d = status.j_last ? S_FIND : S_EX_RD;
			end
			S_FIND: begin
				if (status.found && status.room) begin
					cmd.op = OP_ALLOC;
					state_d = status.acnt_zero ? S_AI_PUT : S_AI_RD;
				end else if (!status.acnt_zero) begin
					cmd.op = OP_VS_INIT;
					state_d = S_VS_CHK;
				end else begin
					cmd.op = OP_SPILL_CUR;
					state_d = S_NEXT;
				end
			end
			S_AI_RD: begin
				cmd.op = OP_AI_RD;
				state_d = S_AI_CMP;
			end
			S_AI_CMP: begin
				cmd.op = OP_AI_CMP;
				if (status.ai_shift && !status.apos_one) begin
					state_d = S_AI_RD;
				end else begin
					state_d = S_AI_PUT;
				end
			end
			S_AI_PUT: begin
				cmd.op = OP_AI_PUT;
				state_d = S_NEXT;
			end
			S_VS_RD: begin
				cmd.op = OP_VS_RD;
				state_d = S_VS_CHK;
			end
			S_VS_CHK: begin
				cmd.op = OP_VS_CHK;
				state_d = status.j_last ? S_VS_DEC : S_VS_RD;
			end
			S_VS_DEC: begin
				if (status.vic_wins) begin
					cmd.op = OP_VS_DEC;
					state_d = S_VS_EVICT;
				end else begin
					cmd.op = OP_SPILL_CUR;
					state_d = S_NEXT;
				end
			end
			S_VS_EVICT: begin
				cmd.op = OP_VS_EVICT;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				cmd.op = OP_NEXT;
				state_d = status.k_last ? S_OUT_RD : S_SC_RD;
			end
			S_OUT_RD: begin
				cmd.op = OP_OUT_RD;
				state_d = S_OUT_RD2;
			end
			S_OUT_RD2: begin
				cmd.op = OP_OUT_RD2;
				state_d = S_OUT_EMIT;
			end
			S_OUT_EMIT: begin
				cmd.op = OP_OUT_EMIT;
				state_d = status.k_last ? S_IDLE : S_OUT_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/lsia_datapath.sv
`default_nettype none
module lsia_datapath import lsia_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int NUM_PHYS = NUM_PHYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	input  wire item_t                 item,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       result_valid,
	output result_t                    result
);

	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int PW = $clog2(NUM_PHYS);
	localparam int AW = PW;
	localparam int ACW = $clog2(NUM_PHYS + 1);
	localparam int VW = (PW > SLOT_W) ? PW : SLOT_W;

	typedef struct packed {
		logic [15:0]   range_start;
		logic [15:0]   range_end;
		logic [IW-1:0] idx;
	} ord_t;

	typedef struct packed {
		logic [IW-1:0] idx;
		logic [15:0]   range_end;
		logic [PW-1:0] preg;
	} act_t;

	typedef struct packed {
		logic          sp;
		logic [VW-1:0] val;
	} asg_t;

	logic [9:0] vreg_mem [MAX_INTERVALS];
	ord_t       ord_mem  [MAX_INTERVALS];
	asg_t       asg_mem  [MAX_INTERVALS];
	act_t       act_mem  [NUM_PHYS];

	logic [CFG_DATA_W-1:0] first_q, scratch_q;
	logic [CW-1:0]         count_q;
	logic                  final_q;
	logic                  res_valid_q;
	result_t               res_q;

	logic [IW-1:0]     pos_q;
	ord_t              new_q, cur_q;
	logic [CW-1:0]     k_q;
	logic [NUM_PHYS-1:0] free_q;
	logic [ACW-1:0]    acnt_q, kept_q;
	logic [AW-1:0]     j_q, apos_q, vi_q;
	logic [PW-1:0]     reg_q;
	act_t              vic_q;
	logic [SLOT_W-1:0] slot_q;

	ord_t       ord_rd_q;
	act_t       act_rd_q;
	asg_t       asg_rd_q;
	logic [9:0] vreg_rd_q;

	logic          ord_we, act_we, asg_we, vreg_we;
	logic [IW-1:0] ord_wa, ord_ra, asg_wa;
	logic [AW-1:0] act_wa, act_ra;
	ord_t          ord_wd;
	act_t          act_wd;
	asg_t          asg_wd;

	logic                found;
	logic [PW-1:0]       fnd_reg;
	logic [NUM_PHYS-1:0] free_init;
	logic                expired, take;

	always_comb begin
		found = 1'b0;
		fnd_reg = '0;
		for (int p = NUM_PHYS - 1; p >= 0; p--) begin
			if (free_q[p] && (p >= int'(first_q))) begin
				found = 1'b1;
				fnd_reg = PW'(p);
			end
		end
		for (int p = 0; p < NUM_PHYS; p++) begin
			free_init[p] = (p != int'(scratch_q));
		end
	end

	assign expired = act_rd_q.range_end < cur_q.range_start;
	assign take = (j_q == '0) || (act_rd_q.range_end > vic_q.range_end);

	always_comb begin
		status.count_full = (count_q == CW'(MAX_INTERVALS));
		status.count_zero = (count_q == '0);
		status.ins_shift = (ord_rd_q.range_start > new_q.range_start);
		status.pos_one = (pos_q == IW'(1));
		status.final_q = final_q;
		status.acnt_zero = (acnt_q == '0);
		status.j_last = ((ACW'(j_q) + ACW'(1)) == acnt_q);
		status.found = found;
		status.room = (acnt_q != ACW'(NUM_PHYS));
		status.ai_shift = (act_rd_q.range_end > cur_q.range_end);
		status.apos_one = (apos_q == AW'(1));
		status.vic_wins = (vic_q.range_end > cur_q.range_end);
		status.k_last = ((k_q + CW'(1)) == count_q);
	end

	// memory port steering
	always_comb begin
		ord_we = 1'b0;
		ord_wa = pos_q;
		ord_wd = new_q;
		ord_ra = k_q[IW-1:0];
		act_we = 1'b0;
		act_wa = apos_q;
		act_wd = act_rd_q;
		act_ra = j_q;
		asg_we = 1'b0;
		asg_wa = cur_q.idx;
		asg_wd = '{sp: 1'b1, val: VW'(slot_q)};
		vreg_we = 1'b0;
		case (cmd.op)
			OP_LOAD: vreg_we = !status.count_full;
			OP_INS_RD: ord_ra = pos_q - IW'(1);
			OP_INS_CMP: begin
				ord_we = status.ins_shift;
				ord_wd = ord_rd_q;
			end
			OP_INS_PUT: ord_we = 1'b1;
			OP_VS_INIT: act_ra = '0;
			OP_AI_RD: act_ra = apos_q - AW'(1);
			OP_EX_CHK: begin
				act_we = !expired;
				act_wa = kept_q[AW-1:0];
			end
			OP_AI_CMP: act_we = status.ai_shift;
			OP_AI_PUT: begin
				act_we = 1'b1;
				act_wd = '{idx: cur_q.idx, range_end: cur_q.range_end, preg: reg_q};
			end
			OP_ALLOC: begin
				asg_we = 1'b1;
				asg_wd = '{sp: 1'b0, val: VW'(fnd_reg)};
			end
			OP_SPILL_CUR: asg_we = 1'b1;
			OP_VS_DEC: begin
				asg_we = 1'b1;
				asg_wd = '{sp: 1'b0, val: VW'(vic_q.preg)};
				act_we = 1'b1;
				act_wa = vi_q;
				act_wd = '{idx: cur_q.idx, range_end: cur_q.range_end, preg: vic_q.preg};
			end
			OP_VS_EVICT: begin
				asg_we = 1'b1;
				asg_wa = vic_q.idx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vreg_we) begin
			vreg_mem[count_q[IW-1:0]] <= item.virtual_reg;
		end
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		if (act_we) begin
			act_mem[act_wa] <= act_wd;
		end
		if (asg_we) begin
			asg_mem[asg_wa] <= asg_wd;
		end
		ord_rd_q <= ord_mem[ord_ra];
		act_rd_q <= act_mem[act_ra];
		asg_rd_q <= asg_mem[ord_rd_q.idx];
		vreg_rd_q <= vreg_mem[ord_rd_q.idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_GENERAL_RST;
			scratch_q <= SCRATCH_RST;
			count_q <= '0;
			final_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (cmd.op == OP_OUT_EMIT);
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FIRST_GENERAL: first_q <= cfg_data;
					CFG_SCRATCH: scratch_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				final_q <= item.final_item;
				if (!status.count_full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if ((cmd.op == OP_OUT_EMIT) && status.k_last) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				new_q <= '{range_start: item.range_start, range_end: item.range_end,
					idx: count_q[IW-1:0]};
				pos_q <= count_q[IW-1:0];
			end
			OP_INS_CMP: begin
				if (status.ins_shift) begin
					pos_q <= pos_q - IW'(1);
				end
			end
			OP_SCAN_INIT: begin
				free_q <= free_init;
				acnt_q <= '0;
				slot_q <= '0;
				k_q <= '0;
			end
			OP_SC_LD: begin
				cur_q <= ord_rd_q;
				j_q <= '0;
				kept_q <= '0;
			end
			OP_EX_CHK: begin
				if (expired) begin
					free_q[act_rd_q.preg] <= 1'b1;
				end else begin
					kept_q <= kept_q + ACW'(1);
				end
				j_q <= j_q + AW'(1);
				if (status.j_last) begin
					acnt_q <= kept_q + ACW'(!expired);
				end
			end
			OP_ALLOC: begin
				free_q[fnd_reg] <= 1'b0;
				reg_q <= fnd_reg;
				apos_q <= acnt_q[AW-1:0];
				acnt_q <= acnt_q + ACW'(1);
			end
			OP_SPILL_CUR: slot_q <= slot_q + SLOT_W'(1);
			OP_VS_INIT: j_q <= '0;
			OP_VS_CHK: begin
				if (take) begin
					vi_q <= j_q;
					vic_q <= act_rd_q;
				end
				j_q <= j_q + AW'(1);
			end
			OP_AI_CMP: begin
				if (status.ai_shift) begin
					apos_q <= apos_q - AW'(1);
				end
			end
			OP_VS_EVICT: slot_q <= slot_q + SLOT_W'(1);
			OP_NEXT: k_q <= status.k_last ? '0 : (k_q + CW'(1));
			OP_OUT_EMIT: begin
				k_q <= k_q + CW'(1);
				res_q.out_virtual_reg <= vreg_rd_q;
				res_q.phys_reg <= asg_rd_q.sp ? 4'd0 : asg_rd_q.val[3:0];
				res_q.spilled <= asg_rd_q.sp;
				res_q.spill_slot <= asg_rd_q.sp ? asg_rd_q.val[SLOT_W-1:0] : '0;
				res_q.last_result <= status.k_last;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule
`default_nettype wire

### rtl/linear_scan_interval_allocator_unit.sv
`default_nettype none
// Linear-scan register allocator. Intervals are loaded one per start pulse while busy is low;
// each load that finds room in the store sorts the interval into place by start, shifting each
// stored interval with a later start before writing the new one. The load flagged final_item
// then runs the scan after a setup state: per interval it fetches the interval and expires
// over the active entries, then either inserts it into the active list (shifting the entries
// with a later end), or searches the entries left for a victim, evicting the victim when its
// end is later and spilling the interval otherwise, or spills it when no entries are left,
// and steps on. After the scan the results are read and emitted one at a time, each shown for
// one cycle with result_valid high; the receiver cannot stall, so results must be taken as
// they come. The cost is set by the order and active-list memories, each read one entry at a
// time through a registered read port. busy stays high from the accepted final item until the
// last result is emitted and is low again in the cycle that shows it. cfg_ready is low while
// busy is high or a word is offered on start.
module linear_scan_interval_allocator_unit import lsia_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int NUM_PHYS = NUM_PHYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire item_t                 item,
	output logic                       result_valid,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = !busy && !start;

	lsia_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (item.final_item),
		.status     (status),
		.busy       (busy),
		.cmd        (cmd)
	);

	lsia_datapath #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.NUM_PHYS      (NUM_PHYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

### rtl/lsia_checker.sv
`default_nettype none
module lsia_checker import lsia_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire result_t result
);

	// nothing follows the final word of a run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_result |=> !result_valid)
		else $error("result after last word");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> busy)
		else $error("idle during a run");

	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.final_item |=> busy)
		else $error("final word did not start a run");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.spilled ? (result.phys_reg == 4'd0)
			: (result.spill_slot == '0)))
		else $error("register and slot both set");

endmodule

bind linear_scan_interval_allocator_unit lsia_checker u_chk (.*);
`default_nettype wire

### sim/linear_scan_interval_allocator_unit_tb.sv
`default_nettype none
module linear_scan_interval_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsia_pkg::*;

	localparam int MAXI = MAX_INTERVALS_DEF;
	localparam int NPHYS = NUM_PHYS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	linear_scan_interval_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// allocator shadow state
	logic [3:0] first_gen = FIRST_GENERAL_RST;
	logic [3:0] scratch = SCRATCH_RST;
	logic [9:0] iv_vreg [MAXI];
	logic [15:0] iv_start [MAXI];
	logic [15:0] iv_end [MAXI];
	int iv_count = 0;

	item_t pending_words[$];
	result_t expected_assignments[$];
	int errors = 0;
	bit quiet_driver = 1'b0;
	bit took = 1'b0;

	task automatic allocate_batch();
		int order [MAXI];
		int act [NPHYS];
		int val [MAXI];
		bit spl [MAXI];
		bit [NPHYS-1:0] free;
		int n, acnt, nslot, cur, pos, kept, reg_sel, vi, victim;
		bit found;
		result_t r;
		n = iv_count;
		for (int i = 0; i < n; i++) begin
			pos = i;
			while (pos > 0 && iv_start[order[pos-1]] > iv_start[i]) begin
				order[pos] = order[pos-1];
				pos--;
			end
			order[pos] = i;
		end
		free = '1;
		if (scratch < NPHYS) free[scratch] = 1'b0;
		acnt = 0;
		nslot = 0;
		for (int k = 0; k < n; k++) begin
			cur = order[k];
			kept = 0;
			for (int j = 0; j < acnt; j++) begin
				if (iv_end[act[j]] < iv_start[cur]) begin
					if (val[act[j]] < NPHYS) free[val[act[j]]] = 1'b1;
				end else begin
					act[kept] = act[j];
					kept++;
				end
			end
			acnt = kept;
			found = 1'b0;
			reg_sel = 0;
			for (int p = first_gen; p < NPHYS; p++) begin
				if (!found && free[p]) begin
					reg_sel = p;
					found = 1'b1;
				end
			end
			if (found && acnt < NPHYS) begin
				free[reg_sel] = 1'b0;
				spl[cur] = 1'b0;
				val[cur] = reg_sel;
				pos = acnt;
				acnt++;
				while (pos > 0 && iv_end[act[pos-1]] > iv_end[cur]) begin
					act[pos] = act[pos-1];
					pos--;
				end
				act[pos] = cur;
			end else if (acnt > 0) begin
				vi = 0;
				for (int j = 1; j < acnt; j++)
					if (iv_end[act[j]] > iv_end[act[vi]]) vi = j;
				victim = act[vi];
				if (iv_end[victim] > iv_end[cur]) begin
					spl[cur] = 1'b0;
					val[cur] = val[victim];
					spl[victim] = 1'b1;
					val[victim] = nslot;
					nslot++;
					act[vi] = cur;
				end else begin
					spl[cur] = 1'b1;
					val[cur] = nslot;
					nslot++;
				end
			end else begin
				spl[cur] = 1'b1;
				val[cur] = nslot;
				nslot++;
			end
		end
		for (int k = 0; k < n; k++) begin
			cur = order[k];
			r.out_virtual_reg = iv_vreg[cur];
			r.phys_reg = spl[cur] ? 4'd0 : 4'(val[cur]);
			r.spilled = spl[cur];
			r.spill_slot = spl[cur] ? SLOT_W'(val[cur]) : '0;
			r.last_result = (k == n - 1);
			expected_assignments.push_back(r);
		end
		iv_count = 0;
	endtask

	task automatic load_interval(input item_t w);
		if (iv_count < MAXI) begin
			iv_vreg[iv_count] = w.virtual_reg;
			iv_start[iv_count] = w.range_start;
			iv_end[iv_count] = w.range_end;
			iv_count++;
		end
		if (w.final_item) allocate_batch();
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || took) begin
				if (pending_words.size() > 0 &&
						(quiet_driver || $urandom_range(99) >= 38)) begin
					item <= pending_words.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		took = start && !busy;
		if (took) load_interval(item);
		if (result_valid) begin
			if (expected_assignments.size() == 0) begin
				$error("unexpected word vreg=%0d", result.out_virtual_reg);
				errors++;
			end else begin
				result_t e;
				e = expected_assignments.pop_front();
				if (result.out_virtual_reg !== e.out_virtual_reg) begin
					$error("out_virtual_reg exp %0d got %0d", e.out_virtual_reg,
						result.out_virtual_reg);
					errors++;
				end
				if (result.phys_reg !== e.phys_reg) begin
					$error("phys_reg exp %0d got %0d", e.phys_reg, result.phys_reg);
					errors++;
				end
				if (result.spilled !== e.spilled) begin
					$error("spilled exp %0d got %0d", e.spilled, result.spilled);
					errors++;
				end
				if (result.spill_slot !== e.spill_slot) begin
					$error("spill_slot exp %0d got %0d", e.spill_slot, result.spill_slot);
					errors++;
				end
				if (result.last_result !== e.last_result) begin
					$error("last_result exp %0d got %0d", e.last_result, result.last_result);
					errors++;
				end
			end
		end
	end

	function automatic item_t mk(input int vr, input int s, input int e, input bit f);
		item_t w;
		w.virtual_reg = 10'(vr);
		w.range_start = 16'(s);
		w.range_end = 16'(e);
		w.final_item = f;
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || start || busy || expected_assignments.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [3:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_FIRST_GENERAL) first_gen = d;
		else scratch = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random batch; mostly short lifetimes so registers recycle
	task automatic push_batch(input int len, input int span);
		int s, l;
		for (int i = 0; i < len; i++) begin
			s = $urandom_range(span);
			l = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(span / 2);
			if ($urandom_range(15) == 0) s = $urandom_range(65535);
			pending_words.push_back(mk($urandom_range(1023), s,
				(s + l > 65535) ? 65535 : s + l, i == len - 1));
		end
	endtask

	initial begin
		int fg_set [6] = '{1, 0, 15, 12, 3, 14};
		int sc_set [6] = '{15, 0, 15, 13, 5, 0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed: extremes, ties, evictions
		pending_words.push_back(mk(0, 0, 0, 1'b1));
		pending_words.push_back(mk(1023, 65535, 65535, 1'b0));
		pending_words.push_back(mk(5, 65535, 0, 1'b0));
		pending_words.push_back(mk(6, 10, 100, 1'b0));
		pending_words.push_back(mk(7, 10, 5, 1'b0));
		pending_words.push_back(mk(8, 0, 65535, 1'b1));
		for (int i = 0; i < 18; i++)
			pending_words.push_back(mk(100 + i, i, 60000 - (i % 3) * 7, i == 17));
		wait_drained();
		// full store then dropped intervals
		write_reg(CFG_FIRST_GENERAL, 4'd15);
		write_reg(CFG_SCRATCH, 4'd0);
		for (int i = 0; i < 70; i++)
			pending_words.push_back(mk($urandom_range(1023), $urandom_range(65535),
				$urandom_range(65535), i == 69));
		wait_drained();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_FIRST_GENERAL, 4'(fg_set[ph]));
			write_reg(CFG_SCRATCH, 4'(sc_set[ph]));
			quiet_driver = (ph == 2);
			for (int b = 0; b < 3; b++)
				push_batch($urandom_range(1, 20), (b % 2) ? 200 : 65535);
			if (ph == 4) push_batch(MAXI, 1000);
			wait_drained();
		end
		quiet_driver = 1'b0;
		repeat (30) @(posedge clk);
		if (errors == 0 && expected_assignments.size() == 0)
			$display("linear_scan_interval_allocator_unit regression: pass");
		else
			$display("linear_scan_interval_allocator_unit regression: fail");
		$finish;
	end

	initial begin
		#50ms;
		$display("linear_scan_interval_allocator_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
